// ===== rtl/gad_pkg.sv =====
package gad_pkg;

  // field widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 13;
  localparam int unsigned ADD_W   = 14;
  // running day count: day + days before month + leap day + largest count
  localparam int unsigned REM_W   = 17;

  // year mod 25 through a reciprocal multiply, exact for any 13 bit year
  localparam int unsigned Q_W     = 9;
  localparam int unsigned M25_W   = 5;
  localparam int unsigned PROD_W  = 2 * YEAR_W;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [YEAR_W-1:0] RECIP_25 = 13'd5243;
  localparam logic [M25_W-1:0]  M25_LAST = 5'd24;

  localparam logic [YEAR_W-1:0]  YEAR_LAST = {YEAR_W{1'b1}};
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_MOD,
    ST_INIT,
    ST_WALK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic quot;
    logic modr;
    logic init;
    logic step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fits;
  } sts_t;

  // length of a month, February by leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      unique case (m)
        4'd2:                 len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        default:              len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    begin
      unique case (m)
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        4'd12:   d = 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

endpackage

// ===== rtl/gad_ctrl.sv =====
module gad_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output gad_pkg::cmd_t cmd,
  input  gad_pkg::sts_t sts
);
  import gad_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.quot  = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.modr  = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (!sts.fits) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output request pending flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ===== rtl/gad_dp.sv =====
module gad_dp #(
  parameter int unsigned MAX_ADD_DAYS = 10000
) (
  input  logic                          clk,
  input  logic [gad_pkg::DAY_W-1:0]     in_start_day,
  input  logic [gad_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [gad_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [gad_pkg::ADD_W-1:0]     in_days_to_add,
  output logic [gad_pkg::DAY_W-1:0]     out_result_day,
  output logic [gad_pkg::MONTH_W-1:0]   out_result_month,
  output logic [gad_pkg::YEAR_W-1:0]    out_result_year,
  input  gad_pkg::cmd_t                 cmd,
  output gad_pkg::sts_t                 sts
);
  import gad_pkg::*;

  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] smon_r, smon_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [REM_W-1:0]   add_r, add_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [M25_W-1:0]   m25_r, m25_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [MONTH_W-1:0] mon_r, mon_nxt;
  logic [DAY_W-1:0]   oday_r;
  logic [MONTH_W-1:0] omon_r;
  logic [YEAR_W-1:0]  oyear_r;

  logic [REM_W-1:0]   add_ext;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  q_times_25;
  logic [YEAR_W-1:0]  year_rem;
  logic               leap;
  logic [DAY_W-1:0]   len;

  // leap year from low bits and year mod 25
  assign leap = (year_r[1:0] == 2'b00) && ((m25_r != '0) || (year_r[3:0] == 4'b0000));
  assign len  = month_len(mon_r, leap);
  assign sts.fits = (rem_r <= REM_W'(len));

  // year / 25 and remainder
  assign prod       = PROD_W'(year_r) * PROD_W'(RECIP_25);
  assign q_times_25 = YEAR_W'({q_r, 4'b0000}) + YEAR_W'({q_r, 3'b000}) + YEAR_W'(q_r);
  assign year_rem   = year_r - q_times_25;

  assign add_ext = REM_W'(in_days_to_add);

  // input capture with clamping
  always_comb begin
    day_nxt  = day_r;
    smon_nxt = smon_r;
    add_nxt  = add_r;
    if (cmd.load) begin
      day_nxt  = (in_start_day == '0) ? DAY_W'(1) : in_start_day;
      if (in_start_month == '0) begin
        smon_nxt = MONTH_JAN;
      end else if (in_start_month > MONTH_DEC) begin
        smon_nxt = MONTH_DEC;
      end else begin
        smon_nxt = in_start_month;
      end
      add_nxt = (add_ext > REM_W'(MAX_ADD_DAYS)) ? REM_W'(MAX_ADD_DAYS) : add_ext;
    end
  end

  // quotient and year mod 25
  always_comb begin
    q_nxt   = cmd.quot ? prod[PROD_W-1-(PROD_W-RECIP_SHIFT-Q_W) -: Q_W] : q_r;
    m25_nxt = m25_r;
    if (cmd.modr) begin
      m25_nxt = year_rem[M25_W-1:0];
    end else if (cmd.step && (mon_r == MONTH_DEC)) begin
      if (year_r == YEAR_LAST || m25_r == M25_LAST) begin
        m25_nxt = '0;
      end else begin
        m25_nxt = m25_r + M25_W'(1);
      end
    end
  end

  // day count and month walk
  always_comb begin
    year_nxt = year_r;
    rem_nxt  = rem_r;
    mon_nxt  = mon_r;
    if (cmd.load) begin
      year_nxt = in_start_year;
    end else if (cmd.init) begin
      rem_nxt = REM_W'(day_r) + REM_W'(days_before(smon_r))
              + REM_W'(leap && (smon_r > MONTH_FEB)) + add_r;
      mon_nxt = MONTH_JAN;
    end else if (cmd.step) begin
      rem_nxt = rem_r - REM_W'(len);
      if (mon_r == MONTH_DEC) begin
        mon_nxt  = MONTH_JAN;
        year_nxt = year_r + YEAR_W'(1);
      end else begin
        mon_nxt = mon_r + MONTH_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    day_r  <= day_nxt;
    smon_r <= smon_nxt;
    year_r <= year_nxt;
    add_r  <= add_nxt;
    q_r    <= q_nxt;
    m25_r  <= m25_nxt;
    rem_r  <= rem_nxt;
    mon_r  <= mon_nxt;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oday_r  <= rem_r[DAY_W-1:0];
      omon_r  <= mon_r;
      oyear_r <= year_r;
    end
  end

  assign out_result_day   = oday_r;
  assign out_result_month = omon_r;
  assign out_result_year  = oyear_r;

endmodule

// ===== rtl/gregorian_add_days.sv =====
// from request accept to result valid the steps are, in order:
// (capture, year/25 quotient, remainder, day count, one walk step per month)
// in_stall holds off a new request until the previous result is emitted,
// and out_stall can hold that emit back
// rst_n is synchronous, active low; it clears the controller and output valid
module gregorian_add_days #(
  parameter int unsigned MAX_ADD_DAYS = 10000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gad_pkg::DAY_W-1:0]   in_start_day,
  input  logic [gad_pkg::MONTH_W-1:0] in_start_month,
  input  logic [gad_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [gad_pkg::ADD_W-1:0]   in_days_to_add,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gad_pkg::DAY_W-1:0]   out_result_day,
  output logic [gad_pkg::MONTH_W-1:0] out_result_month,
  output logic [gad_pkg::YEAR_W-1:0]  out_result_year
);
  import gad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // date arithmetic
  gad_dp #(
    .MAX_ADD_DAYS (MAX_ADD_DAYS)
  ) u_dp (
    .clk              (clk),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .in_days_to_add   (in_days_to_add),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
